>>> hw/rtl/button_debounce_mode_select_top_defines.svh
// Assertion macros shared by the button debounce / mode select RTL.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef BUTTON_DEBOUNCE_MODE_SELECT_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_MODE_SELECT_TOP_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define BDMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication form.
`define BDMS_ASSERT_IMP(lbl, ante, cons, msg) \
  `BDMS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define BDMS_ASSERT_NXT(lbl, ante, cons, msg) \
  `BDMS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/bdms_pkg.sv
// Package for the button debounce / mode select block: types, codes, reset values.
// No dependencies.
`timescale 1ns / 1ps
package bdms_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned TempW  = 8;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned CfgW   = 16;

  localparam logic [CodeW-1:0] UpBit   = 2'b01;
  localparam logic [CodeW-1:0] DownBit = 2'b10;

  localparam logic [TimerW-1:0] DebounceRst = 16'd20;
  localparam logic [TimerW-1:0] HoldRst     = 16'd2000;
  localparam logic [TimerW-1:0] IdleRst     = 16'd10000;
  localparam logic [TempW-1:0]  SavedRst    = 8'd0;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_IDLE     = 2'd2,
    CFG_SAVED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_ADJUST = 2'd2
  } phase_e;

  typedef struct packed {
    logic signed [TempW-1:0] set_temperature;
    logic                    down_pin_level;
    logic                    up_pin_level;
  } in_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] saved_value;
    logic                    save_strobe;
    logic [CodeW-1:0]        button_status;
    logic [CodeW-1:0]        op_mode;
  } result_t;

endpackage

>>> hw/rtl/bdms_in_stage.sv
// Input register for the tick stream: holds one beat until the tick logic takes it.
// Depends on bdms_pkg.
`timescale 1ns / 1ps
module bdms_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  bdms_pkg::in_item_t  s_item_i,
  input  logic                take_i,
  output logic                valid_o,
  output bdms_pkg::in_item_t  item_o
);
  import bdms_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // free when empty or emptied this cycle
  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = (s_valid_i && s_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/bdms_tick.sv
// Per-tick state update: config registers, timers, debouncer and mode phase machine.
// Depends on bdms_pkg.
`timescale 1ns / 1ps
module bdms_tick (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [bdms_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        step_i,
  input  bdms_pkg::in_item_t          item_i,
  output bdms_pkg::result_t           res_o
);
  import bdms_pkg::*;

  logic [TimerW-1:0] debounce_q, hold_t_q, idle_t_q;
  logic [TimerW-1:0] sample_cnt_q, sample_cnt_d;
  logic [TimerW-1:0] hold_cnt_q, hold_cnt_d;
  logic [TimerW-1:0] idle_cnt_q, idle_cnt_d;
  logic [CodeW-1:0]  last_q, last_d;
  logic [CodeW-1:0]  stable_q, stable_d;
  logic [CodeW-1:0]  mode_q, mode_d;
  logic [TempW-1:0]  saved_q, saved_d;
  phase_e            phase_q, phase_d;

  logic [TimerW-1:0] sample_dec, hold_dec, idle_dec;
  logic [CodeW-1:0]  code;
  logic              strobe;

  assign sample_dec = (sample_cnt_q != '0) ? sample_cnt_q - 1'b1 : '0;
  assign hold_dec   = (hold_cnt_q != '0) ? hold_cnt_q - 1'b1 : '0;
  assign idle_dec   = (idle_cnt_q != '0) ? idle_cnt_q - 1'b1 : '0;

  assign code = (item_i.up_pin_level ? '0 : UpBit) | (item_i.down_pin_level ? '0 : DownBit);

  // debouncer: sample when the countdown has run out
  always_comb begin
    sample_cnt_d = sample_dec;
    last_d       = last_q;
    stable_d     = stable_q;
    if (sample_dec == '0) begin
      sample_cnt_d = debounce_q;
      if (code != last_q) begin
        last_d = code;
      end else begin
        stable_d = code;
      end
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_WAIT: begin
        if (stable_d != '0) phase_d = PH_HOLD;
      end
      PH_HOLD: begin
        if (hold_dec == '0 && stable_d != '0) phase_d = PH_ADJUST;
        if (stable_d == '0) phase_d = PH_WAIT;
      end
      PH_ADJUST: begin
        if (idle_dec == '0) phase_d = PH_WAIT;
      end
      default: phase_d = PH_WAIT;
    endcase
  end

  // phase outputs: timers, mode, saved copy
  always_comb begin
    hold_cnt_d = hold_dec;
    idle_cnt_d = idle_dec;
    mode_d     = mode_q;
    saved_d    = saved_q;
    strobe     = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        if (stable_d != '0) hold_cnt_d = hold_t_q;
      end
      PH_HOLD: begin
        if (hold_dec == '0) begin
          if (stable_d != '0) mode_d = stable_d;
          idle_cnt_d = idle_t_q;
        end
      end
      PH_ADJUST: begin
        if (idle_dec == '0) begin
          if (saved_q != item_i.set_temperature) begin
            saved_d = item_i.set_temperature;
            strobe  = 1'b1;
          end
          mode_d = '0;
        end
        if (stable_d != '0) idle_cnt_d = idle_t_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      hold_t_q     <= HoldRst;
      idle_t_q     <= IdleRst;
      sample_cnt_q <= '0;
      hold_cnt_q   <= '0;
      idle_cnt_q   <= '0;
      last_q       <= '0;
      stable_q     <= '0;
      mode_q       <= '0;
      saved_q      <= SavedRst;
      phase_q      <= PH_WAIT;
    end else if (cfg_we_i) begin
      // the user must write only while idle, so no tick competes; the block does not enforce it
      case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_HOLD:     hold_t_q   <= cfg_data_i;
        CFG_IDLE:     idle_t_q   <= cfg_data_i;
        CFG_SAVED:    saved_q    <= cfg_data_i[TempW-1:0];
        default: ;
      endcase
    end else if (step_i) begin
      sample_cnt_q <= sample_cnt_d;
      hold_cnt_q   <= hold_cnt_d;
      idle_cnt_q   <= idle_cnt_d;
      last_q       <= last_d;
      stable_q     <= stable_d;
      mode_q       <= mode_d;
      saved_q      <= saved_d;
      phase_q      <= phase_d;
    end
  end

  assign res_o.op_mode       = mode_d;
  assign res_o.button_status = stable_d;
  assign res_o.save_strobe   = strobe;
  assign res_o.saved_value   = saved_d;

endmodule

>>> hw/rtl/button_debounce_mode_select_top.sv
// Button debounce / long-press mode select, top level with output register.
// Depends on bdms_pkg, bdms_in_stage, bdms_tick and the assertion macro header.
//
//   channel   | dir | beat content (low bit first)
//   ----------+-----+------------------------------------------------------
//   s_axis    | in  | up_pin_level, down_pin_level, set_temperature[7:0]
//   m_axis    | out | op_mode[1:0], button_status[1:0], save_strobe,
//             |     | saved_value[7:0]
//   cfg       | in  | cfg_idx_i selects register, cfg_data_i value, cfg_we_i write
//
// One beat in gives one beat out. A beat passes the input register, then the
// tick update lands in the state and output registers together.
// A new tick can be taken every cycle while m_axis takes results; the state update
// is a single pass of decrement, compare and select logic from the input register.
// Reset (rst_ni low, async) loads register defaults and clears all timers and
// the debouncer. A stalled m_axis holds the result; the input register then
// fills and s_axis_tready_o drops until the result is taken.
`timescale 1ns / 1ps
`include "button_debounce_mode_select_top_defines.svh"
module button_debounce_mode_select_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // up_pin_level, down_pin_level, set_temperature, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // op_mode, button_status, save_strobe,
                                       // saved_value, pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [bdms_pkg::CfgW-1:0] cfg_data_i
);
  import bdms_pkg::*;

  localparam int unsigned InW  = $bits(in_item_t);
  localparam int unsigned ResW = $bits(result_t);

  in_item_t s_item, in_item;
  logic     in_valid;
  logic     advance;
  result_t  res;
  result_t  out_q;
  logic     out_valid_q, out_valid_d;

  assign s_item = in_item_t'(s_axis_tdata_i[InW-1:0]);

  // tick moves on when the output register is free or being emptied
  assign advance     = in_valid && (!out_valid_q || m_axis_tready_i);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  bdms_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .take_i    (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  bdms_tick u_tick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (in_item),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16-ResW){1'b0}}, out_q};

  // a save always coincides with the return to idle mode
  `BDMS_ASSERT_IMP(a_strobe_idle, out_valid_q && out_q.save_strobe,
                   out_q.op_mode == '0, "save strobe with nonzero mode")
  // a save copies the temperature of the same tick
  `BDMS_ASSERT_IMP(a_strobe_temp, advance && res.save_strobe,
                   res.saved_value == in_item.set_temperature,
                   "saved value differs from tick temperature")
  // a finished tick always lands in the output register
  `BDMS_ASSERT_NXT(a_adv_out, advance, out_valid_q, "result lost after tick")
  // a held tick is not dropped from the input register
  `BDMS_ASSERT_NXT(a_in_hold, in_valid && !advance, in_valid, "pending tick dropped")

endmodule

>>> test/tb.sv
// Self-checking testbench for button_debounce_mode_select_top: debounce, long press,
// idle timeout and save strobe, checked beat by beat. Needs bdms_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
  import bdms_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 6;  // input and output registers plus margin

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // up_pin_level, down_pin_level, set_temperature, pad
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // op_mode, button_status, save_strobe,
                                     // saved_value, pad
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  button_debounce_mode_select_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: timer settings, countdowns, debouncer and the
  // wait / hold / adjust machine. Updated once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [TimerW-1:0] debounce_set, hold_set, idle_set;
  logic [TimerW-1:0] sample_left, hold_left, idle_left;
  logic [CodeW-1:0]  prev_code, status_now, mode_now;
  logic [1:0]        phase_now;
  logic signed [TempW-1:0] saved_now;

  in_item_t pin_ticks_q[$];      // ticks still to be sent
  result_t  tick_results_q[$];   // predicted outputs, oldest first

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 58;
  logic        in_beat = 1'b0;   // input beat taken at the last rising edge
  logic signed [TempW-1:0] run_temp = '0;

  function automatic logic [TimerW-1:0] count_down(logic [TimerW-1:0] t);
    return (t != '0) ? t - 1'b1 : '0;
  endfunction

  function automatic result_t predict_tick(in_item_t it);
    logic [CodeW-1:0] code;
    result_t r;
    r = '0;
    sample_left = count_down(sample_left);
    hold_left   = count_down(hold_left);
    idle_left   = count_down(idle_left);

    // debouncer: sample when the countdown runs out, accept on two equal samples
    if (sample_left == '0) begin
      sample_left = debounce_set;
      code = '0;
      if (!it.up_pin_level) code = code | UpBit;
      if (!it.down_pin_level) code = code | DownBit;
      if (code != prev_code) prev_code = code;
      else status_now = code;
    end

    case (phase_now)
      PH_WAIT: begin
        if (status_now != '0) begin
          hold_left = hold_set;
          phase_now = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (hold_left == '0) begin
          if (status_now != '0) begin
            mode_now  = status_now;
            phase_now = PH_ADJUST;
          end
          idle_left = idle_set;
        end
        // release before the hold time keeps the old mode
        if (status_now == '0) phase_now = PH_WAIT;
      end
      PH_ADJUST: begin
        if (idle_left == '0) begin
          if (saved_now != it.set_temperature) begin
            saved_now = it.set_temperature;
            r.save_strobe = 1'b1;
          end
          phase_now = PH_WAIT;
          mode_now  = '0;
        end
        if (status_now != '0) idle_left = idle_set;
      end
      default: phase_now = PH_WAIT;
    endcase

    r.op_mode       = mode_now;
    r.button_status = status_now;
    r.saved_value   = saved_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("tb: mismatch %s got 0x%0h want 0x%0h at cycle %0d", what, got, want,
             cycle_cnt);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Edge sampling: cycle limit, input beats feed the predictor, output beats
  // are checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycle_cnt);
      $display("tb: FAIL");
      $finish;
    end else if (rst_ni) begin
      in_beat <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tick_results_q.push_back(
          predict_tick(in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0])));
        void'(pin_ticks_q.pop_front());
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
        if (m_axis_tdata_o[15:$bits(result_t)] != '0)
          report_mismatch("pad", m_axis_tdata_o, '0);
        if (tick_results_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata_o, '0);
        end else begin
          want = tick_results_q.pop_front();
          if (got.op_mode != want.op_mode)
            report_mismatch("op_mode", 16'(got.op_mode), 16'(want.op_mode));
          if (got.button_status != want.button_status)
            report_mismatch("button_status", 16'(got.button_status),
                            16'(want.button_status));
          if (got.save_strobe != want.save_strobe)
            report_mismatch("save_strobe", 16'(got.save_strobe), 16'(want.save_strobe));
          if (got.saved_value != want.saved_value)
            report_mismatch("saved_value", 16'(got.saved_value), 16'(want.saved_value));
        end
      end
    end
  end

  // Driver: a beat stays up until taken; a new one is offered only after that.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_beat) begin
        if (pin_ticks_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= 16'(pin_ticks_q[0]);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // press is the set of held buttons (bit0 up, bit1 down); pins are active low
  task automatic push_tick(logic [CodeW-1:0] press, logic signed [TempW-1:0] temp);
    in_item_t it;
    it.up_pin_level    = ~press[0];
    it.down_pin_level  = ~press[1];
    it.set_temperature = temp;
    pin_ticks_q.push_back(it);
  endtask

  // Register write at a falling edge; we stays high across back-to-back writes.
  task automatic cfg_write(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DEBOUNCE: debounce_set = val;
      CFG_HOLD:     hold_set = val;
      CFG_IDLE:     idle_set = val;
      CFG_SAVED:    saved_now = val[TempW-1:0];  // presets the saved copy at once
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [CfgW-1:0] deb, logic [CfgW-1:0] hold,
                           logic [CfgW-1:0] idle, logic signed [TempW-1:0] saved);
    cfg_write(CFG_DEBOUNCE, deb);
    cfg_write(CFG_HOLD, hold);
    cfg_write(CFG_IDLE, idle);
    cfg_write(CFG_SAVED, {{(CfgW-TempW){saved[TempW-1]}}, saved});
    cfg_done();
  endtask

  // Sender stops until every predicted beat has come back and the block is quiet.
  task automatic drain();
    while (pin_ticks_q.size() != 0 || tick_results_q.size() != 0 || s_axis_tvalid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly full press / release runs that walk the whole mode machine, with
  // some pin noise and short, broken presses mixed in.
  task automatic gen_presses(int unsigned count, int unsigned run_max);
    int unsigned made, kind, len, rel;
    logic [CodeW-1:0] press;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      // reuse the temperature half the time so unchanged saves occur too
      if ($urandom_range(0, 1)) run_temp = TempW'($urandom);
      if (kind < 7) begin
        press = CodeW'($urandom_range(1, 3));
        len = $urandom_range(1, run_max);
        rel = $urandom_range(1, 2 * run_max);
        repeat (len) push_tick(press, run_temp);
        repeat (rel) push_tick('0, run_temp);
      end else if (kind < 9) begin
        len = $urandom_range(1, 6);
        rel = 0;
        repeat (len) push_tick(CodeW'($urandom_range(0, 3)), TempW'($urandom));
      end else begin
        len = $urandom_range(1, 2);
        rel = $urandom_range(1, 3);
        repeat (len) push_tick(CodeW'($urandom_range(1, 3)), run_temp);
        repeat (rel) push_tick('0, run_temp);
      end
      made += len + rel;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    debounce_set = DebounceRst;
    hold_set     = HoldRst;
    idle_set     = IdleRst;
    saved_now    = SavedRst;
    sample_left  = '0;
    hold_left    = '0;
    idle_left    = '0;
    prev_code    = '0;
    status_now   = '0;
    mode_now     = '0;
    phase_now    = PH_WAIT;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: sample every tick, short hold and idle, saved copy at its minimum
    configure(16'd0, 16'd2, 16'd2, -8'sd128);
    repeat (4) push_tick(UpBit, 8'sd127);           // up long press
    repeat (4) push_tick('0, 8'sd127);              // idle expiry saves 127
    push_tick(UpBit | DownBit, -8'sd128);           // both, too short to pass the debouncer
    repeat (2) push_tick('0, -8'sd128);
    repeat (5) push_tick(DownBit, 8'sd127);         // down long press
    repeat (5) push_tick('0, 8'sd127);              // expiry, temperature unchanged
    repeat (4) push_tick(UpBit | DownBit, -8'sd128);
    drain();

    // zero timers everywhere, saved copy at its maximum
    configure(16'd0, 16'd0, 16'd0, 8'sd127);
    gen_presses(200, 6);
    drain();

    // sender idling more, receiver stalling less; pause midway until all results are in
    tx_idle_pct = 58;
    rx_idle_pct = 31;
    configure(16'd1, 16'd3, 16'd5, TempW'($urandom));
    gen_presses(175, 16);
    drain();
    gen_presses(175, 16);
    drain();

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(16'd2, 16'd1, 16'd1, 8'sd0);
    gen_presses(300, 12);
    drain();

    // timers at their maximum
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, -8'sd1);
    gen_presses(100, 4);
    drain();

    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bdms_pkg.sv
hw/rtl/bdms_in_stage.sv
hw/rtl/bdms_tick.sv
hw/rtl/button_debounce_mode_select_top.sv
test/tb.sv
